### design/sqs_pkg.sv
// ---------------------------------------------------------------------------
// sqs_pkg
// Shared constants, codes and types of the quality sampler.
// ---------------------------------------------------------------------------
package sqs_pkg;

  localparam int MaxQualityLen = 1024;
  localparam int FillW         = $clog2(MaxQualityLen + 1);
  localparam int BufAw         = $clog2(MaxQualityLen);
  localparam int CountW        = 32;
  localparam int HistDepth     = 256;
  localparam int BinW          = 8;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Input functions
  localparam logic [1:0] FnByte  = 2'd0;
  localparam logic [1:0] FnEnd   = 2'd1;
  localparam logic [1:0] FnRead  = 2'd2;
  localparam logic [1:0] FnClear = 2'd3;

  // Line status codes
  localparam logic [2:0] StAccepted = 3'd0;
  localparam logic [2:0] StHeader   = 3'd1;
  localparam logic [2:0] StFew      = 3'd2;
  localparam logic [2:0] StNoQual   = 3'd3;
  localparam logic [2:0] StOverBud  = 3'd4;
  localparam logic [2:0] StTooLong  = 3'd5;
  localparam logic [2:0] StScanStop = 3'd6;

  // Result kinds
  localparam logic KindLine = 1'b0;
  localparam logic KindBin  = 1'b1;

  // Register indexes
  localparam logic RegScanBudget = 1'b0;
  localparam logic RegQualBudget = 1'b1;

  // Columns
  localparam logic [3:0] ColFlag = 4'd1;
  localparam logic [3:0] ColSeq  = 4'd9;
  localparam logic [3:0] ColQual = 4'd10;
  localparam logic [3:0] ColPast = 4'd11;

  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Parse state of the current line
  typedef struct packed {
    logic [3:0]       col;
    logic [4:0]       flag_res;
    logic             flag_done;
    logic             has_bytes;
    logic             header;
    logic             over;
    logic             first_star;
    logic [15:0]      seq_len;
    logic [15:0]      qual_len;
    logic [FillW-1:0] fill;
  } sqs_line_t;

endpackage

### design/sqs_if.sv
// ---------------------------------------------------------------------------
// sqs_if
// Channel interfaces of the quality sampler: input, result and config.
// ---------------------------------------------------------------------------
interface sqs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] text_byte;
  logic [7:0] bin_index;
  modport source (output valid, func, text_byte, bin_index, input ready);
  modport sink   (input valid, func, text_byte, bin_index, output ready);
endinterface

interface sqs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  line_status;
  logic        reverse_strand;
  logic [15:0] quality_length;
  logic [15:0] sequence_length;
  logic [39:0] collected_total;
  logic [31:0] bin_count;
  modport source (output valid, result_kind, line_status, reverse_strand, quality_length,
                  sequence_length, collected_total, bin_count, input ready);
  modport sink   (input valid, result_kind, line_status, reverse_strand, quality_length,
                  sequence_length, collected_total, bin_count, output ready);
endinterface

interface sqs_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [39:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/sqs_ram.sv
// ---------------------------------------------------------------------------
// sqs_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module sqs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, then read through the registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/sqs_line_parser.sv
// ---------------------------------------------------------------------------
// sqs_line_parser
// Column tracker of one SAM line: FLAG residue, SEQ and QUAL lengths, and
// the write port into the quality buffer.
// ---------------------------------------------------------------------------
module sqs_line_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_en_i,
  input  logic [7:0]               byte_i,
  input  logic                     clear_i,
  output sqs_pkg::sqs_line_t       line_o,
  output logic                     buf_we_o,
  output logic [sqs_pkg::BufAw-1:0] buf_waddr_o,
  output logic [7:0]               buf_wdata_o
);

  sqs_pkg::sqs_line_t line_q, line_d;
  logic               is_header;
  logic               is_digit;

  assign is_header   = line_q.header | (!line_q.has_bytes && byte_i == sqs_pkg::ChAt);
  assign is_digit    = (byte_i >= sqs_pkg::ChZero) && (byte_i <= sqs_pkg::ChNine);
  assign buf_waddr_o = line_q.fill[sqs_pkg::BufAw-1:0];
  assign buf_wdata_o = byte_i;
  assign line_o      = line_q;

  // Advance the column state by one byte
  always_comb begin
    line_d   = line_q;
    buf_we_o = 1'b0;
    if (clear_i) begin
      line_d = '0;
    end else if (byte_en_i) begin
      line_d.has_bytes = 1'b1;
      line_d.header    = is_header;
      if (!is_header) begin
        if (byte_i == sqs_pkg::ChTab) begin
          if (line_q.col < sqs_pkg::ColPast) line_d.col = line_q.col + 4'd1;
        end else if (line_q.col == sqs_pkg::ColFlag) begin
          if (!line_q.flag_done) begin
            if (is_digit) begin
              line_d.flag_res = 5'(({3'b0, line_q.flag_res} * 8'd10)
                                   + (byte_i - sqs_pkg::ChZero));
            end else begin
              line_d.flag_done = 1'b1;
            end
          end
        end else if (line_q.col == sqs_pkg::ColSeq) begin
          if (line_q.seq_len != 16'hFFFF) line_d.seq_len = line_q.seq_len + 16'd1;
        end else if (line_q.col == sqs_pkg::ColQual) begin
          if (line_q.qual_len != 16'hFFFF) line_d.qual_len = line_q.qual_len + 16'd1;
          if (line_q.fill < sqs_pkg::FillW'(sqs_pkg::MaxQualityLen)) begin
            buf_we_o    = 1'b1;
            line_d.fill = line_q.fill + sqs_pkg::FillW'(1);
            if (line_q.fill == '0) line_d.first_star = (byte_i == sqs_pkg::ChStar);
          end else begin
            line_d.over = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else begin
      line_q <= line_d;
    end
  end

endmodule

### design/sqs_hist_engine.sv
// ---------------------------------------------------------------------------
// sqs_hist_engine
// Histogram memory with per-bin valid bits and a read-modify-write pass
// over the buffered quality bytes of an accepted line.
// ---------------------------------------------------------------------------
module sqs_hist_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sqs_pkg::FillW-1:0] fill_i,
  input  logic                      clear_i,
  input  logic [sqs_pkg::BinW-1:0]  bin_index_i,
  output logic [sqs_pkg::BufAw-1:0] buf_raddr_o,
  input  logic [7:0]                buf_rdata_i,
  output logic [31:0]               bin_count_o,
  output logic                      busy_o
);

  logic [sqs_pkg::FillW-1:0]   issue_q, fill_q;
  logic                        act_q, p1_q, p2_q;
  logic [sqs_pkg::BinW-1:0]    bin2_q, wr_bin_q;
  logic                        wr_q;
  logic [sqs_pkg::CountW-1:0]  wr_val_q;
  logic [sqs_pkg::HistDepth-1:0] hvalid_q;
  logic                        bin_ok_q;
  logic [sqs_pkg::BinW-1:0]    hist_raddr;
  logic [sqs_pkg::CountW-1:0]  hist_rdata, old_val, new_val;
  logic                        issue_now;

  assign issue_now   = act_q && (issue_q != fill_q);
  assign buf_raddr_o = issue_q[sqs_pkg::BufAw-1:0];
  assign hist_raddr  = p1_q ? buf_rdata_i : bin_index_i;
  assign busy_o      = act_q | p1_q | p2_q;
  assign bin_count_o = bin_ok_q ? hist_rdata[31:0] : 32'd0;

  // Forward the previous write, else take the stored count of a valid bin, else zero
  always_comb begin
    if (wr_q && wr_bin_q == bin2_q) begin
      old_val = wr_val_q;
    end else if (hvalid_q[bin2_q]) begin
      old_val = hist_rdata;
    end else begin
      old_val = '0;
    end
    new_val = (old_val == sqs_pkg::CountMax) ? old_val : old_val + sqs_pkg::CountW'(1);
  end

  sqs_ram #(
    .Width (sqs_pkg::CountW),
    .Depth (sqs_pkg::HistDepth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (p2_q),
    .waddr_i (bin2_q),
    .wdata_i (new_val),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Sequence the update pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      p1_q     <= 1'b0;
      p2_q     <= 1'b0;
      wr_q     <= 1'b0;
      hvalid_q <= '0;
      issue_q  <= '0;
      fill_q   <= '0;
    end else begin
      p1_q <= issue_now;
      p2_q <= p1_q;
      wr_q <= p2_q;
      if (start_i) begin
        act_q   <= 1'b1;
        issue_q <= '0;
        fill_q  <= fill_i;
      end else if (issue_now) begin
        issue_q <= issue_q + sqs_pkg::FillW'(1);
      end else begin
        act_q <= 1'b0;
      end
      if (clear_i) begin
        hvalid_q <= '0;
      end else if (p2_q) begin
        hvalid_q[bin2_q] <= 1'b1;
      end
    end
  end

  // Hold the payload of the pipeline
  always_ff @(posedge clk_i) begin
    bin2_q   <= buf_rdata_i;
    wr_bin_q <= bin2_q;
    wr_val_q <= new_val;
    bin_ok_q <= hvalid_q[bin_index_i];
  end

endmodule

### design/sam_quality_sampler_unit.sv
// ---------------------------------------------------------------------------
// sam_quality_sampler_unit
// SAM quality-column sampler with a 256-bin quality histogram.
// ---------------------------------------------------------------------------
// Use: items enter on in_ch_i (func, text_byte, bin_index); line reports and
// bin counts leave on out_ch_o; cfg_ch_i writes scan_budget (index 0) and
// quality_budget (index 1) and is always ready.
// A newline, or an end of block after a partial line, yields a report in the
// output register in the cycle after acceptance unless scanning has stopped.
// An accepted line then runs a histogram pass, one quality byte per cycle
// through the buffer read port and the histogram read-modify-write, with
// forwarding between consecutive updates of one bin. A bin read answers in SBin.
// The block takes one item at a time: ready is high only when the sequencer
// is idle and the output register is empty, so a stalled receiver holds
// the block. At reset budgets go to all ones, totals and parse state clear,
// and the histogram valid bits clear at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sam_quality_sampler_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sqs_in_if.sink     in_ch_i,
  sqs_out_if.source  out_ch_o,
  sqs_cfg_if.sink    cfg_ch_i
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SBin  = 2'd1;
  localparam logic [1:0] SHist = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] scan_budget_q;
  logic [39:0] qual_budget_q;
  logic [39:0] accepted_q;
  logic [31:0] scanned_q, scan_new;
  logic        stopped_q;
  logic        in_acc;
  logic        is_nl;
  logic        end_now;
  logic        byte_en;
  logic        line_clear;
  logic [2:0]  status;
  logic [40:0] sum;
  logic        hist_start;
  logic        hist_busy;
  logic [31:0] bin_count;

  sqs_pkg::sqs_line_t        line;
  logic                      buf_we;
  logic [sqs_pkg::BufAw-1:0] buf_waddr, buf_raddr;
  logic [7:0]                buf_wdata, buf_rdata;

  logic        ov_q;
  logic        kind_q, rev_q;
  logic [2:0]  st_q;
  logic [15:0] qlen_q, slen_q;
  logic [39:0] total_q;
  logic [31:0] cnt_q;

  assign in_ch_i.ready  = (state_q == SIdle) && !ov_q;
  assign in_acc         = in_ch_i.valid && in_ch_i.ready;
  assign cfg_ch_i.ready = 1'b1;
  assign is_nl          = in_ch_i.text_byte == sqs_pkg::ChLf;

  // Decode the accepted item
  always_comb begin
    end_now = 1'b0;
    byte_en = 1'b0;
    if (in_acc && !stopped_q) begin
      unique case (in_ch_i.func)
        sqs_pkg::FnByte: begin
          end_now = is_nl;
          byte_en = !is_nl;
        end
        sqs_pkg::FnEnd:  end_now = line.has_bytes;
        default:         ;
      endcase
    end
  end
  assign line_clear = end_now || (in_acc && in_ch_i.func == sqs_pkg::FnEnd);

  // Classify the ending line
  assign scan_new = (in_ch_i.func == sqs_pkg::FnByte && scanned_q != 32'hFFFF_FFFF)
                    ? scanned_q + 32'd1 : scanned_q;
  assign sum      = {1'b0, accepted_q} + 41'(line.fill);
  always_comb begin
    if (scan_new >= scan_budget_q) begin
      status = sqs_pkg::StScanStop;
    end else if (!line.has_bytes || line.header) begin
      status = sqs_pkg::StHeader;
    end else if (line.col < sqs_pkg::ColQual) begin
      status = sqs_pkg::StFew;
    end else if (!line.over && (line.fill == '0 ||
                 (line.fill == sqs_pkg::FillW'(1) && line.first_star))) begin
      status = sqs_pkg::StNoQual;
    end else if (line.over) begin
      status = sqs_pkg::StTooLong;
    end else if (sum > {1'b0, qual_budget_q}) begin
      status = sqs_pkg::StOverBud;
    end else begin
      status = sqs_pkg::StAccepted;
    end
  end
  assign hist_start = end_now && status == sqs_pkg::StAccepted;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (in_acc && in_ch_i.func == sqs_pkg::FnRead) state_d = SBin;
        else if (hist_start)                           state_d = SHist;
      end
      SBin:    state_d = SIdle;
      SHist:   if (!hist_busy) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  sqs_line_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (byte_en),
    .byte_i      (in_ch_i.text_byte),
    .clear_i     (line_clear),
    .line_o      (line),
    .buf_we_o    (buf_we),
    .buf_waddr_o (buf_waddr),
    .buf_wdata_o (buf_wdata)
  );

  sqs_ram #(
    .Width (8),
    .Depth (sqs_pkg::MaxQualityLen)
  ) u_qual_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  sqs_hist_engine u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (hist_start),
    .fill_i      (line.fill),
    .clear_i     (in_acc && in_ch_i.func == sqs_pkg::FnClear),
    .bin_index_i (in_ch_i.bin_index),
    .buf_raddr_o (buf_raddr),
    .buf_rdata_i (buf_rdata),
    .bin_count_o (bin_count),
    .busy_o      (hist_busy)
  );

  // Hold control state, totals and budgets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      scan_budget_q <= 32'hFFFF_FFFF;
      qual_budget_q <= 40'hFF_FFFF_FFFF;
      accepted_q    <= '0;
      scanned_q     <= '0;
      stopped_q     <= 1'b0;
      ov_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_ch_i.valid) begin
        if (cfg_ch_i.index == sqs_pkg::RegScanBudget) scan_budget_q <= cfg_ch_i.data[31:0];
        else                                          qual_budget_q <= cfg_ch_i.data;
      end
      if (byte_en && scanned_q != 32'hFFFF_FFFF) scanned_q <= scanned_q + 32'd1;
      if (end_now) begin
        scanned_q <= scan_new;
        if (status == sqs_pkg::StScanStop) stopped_q <= 1'b1;
        if (hist_start) accepted_q <= sum[39:0];
      end
      if (in_acc && in_ch_i.func == sqs_pkg::FnEnd) begin
        scanned_q <= '0;
        stopped_q <= 1'b0;
      end
      if (in_acc && in_ch_i.func == sqs_pkg::FnClear) accepted_q <= '0;
      if (end_now || state_q == SBin) ov_q <= 1'b1;
      else if (out_ch_o.ready)        ov_q <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (end_now) begin
      kind_q  <= sqs_pkg::KindLine;
      st_q    <= status;
      cnt_q   <= '0;
      total_q <= hist_start ? sum[39:0] : accepted_q;
      if (status == sqs_pkg::StScanStop || status == sqs_pkg::StHeader) begin
        rev_q  <= 1'b0;
        qlen_q <= '0;
        slen_q <= '0;
      end else begin
        rev_q  <= line.flag_res[4];
        qlen_q <= line.qual_len;
        slen_q <= line.seq_len;
      end
    end else if (state_q == SBin) begin
      kind_q  <= sqs_pkg::KindBin;
      st_q    <= '0;
      rev_q   <= 1'b0;
      qlen_q  <= '0;
      slen_q  <= '0;
      total_q <= accepted_q;
      cnt_q   <= bin_count;
    end
  end

  assign out_ch_o.valid           = ov_q;
  assign out_ch_o.result_kind     = kind_q;
  assign out_ch_o.line_status     = st_q;
  assign out_ch_o.reverse_strand  = rev_q;
  assign out_ch_o.quality_length  = qlen_q;
  assign out_ch_o.sequence_length = slen_q;
  assign out_ch_o.collected_total = total_q;
  assign out_ch_o.bin_count       = cnt_q;

  // Checks
  a_busy_in_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_busy |-> state_q == SHist) else $error("histogram pass outside SHist");
  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SIdle |-> !in_ch_i.ready) else $error("ready while sequencer busy");
  a_read_to_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_ch_i.func == sqs_pkg::FnRead) |=> state_q == SBin)
    else $error("bin read did not enter SBin");

endmodule
